// ----- src/ifs_pkg.sv -----
// Shared types, constants and helper functions of the field splitter.
package ifs_pkg;

  localparam int unsigned HoldDepth   = 32;
  localparam int unsigned HoldAw      = $clog2(HoldDepth);
  localparam int unsigned MaxNames    = 32;
  localparam int unsigned IfsSlots    = 8;
  localparam int unsigned ResultLimit = 34;
  localparam int unsigned FifoDepth   = 2;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharNewline   = 8'h0A;

  localparam logic [1:0] CfgIfsChars  = 2'd0;
  localparam logic [1:0] CfgIfsCount  = 2'd1;
  localparam logic [1:0] CfgRawMode   = 2'd2;
  localparam logic [1:0] CfgNameCount = 2'd3;

  localparam logic [1:0] KindChar  = 2'd0;
  localparam logic [1:0] KindClose = 2'd1;
  localparam logic [1:0] KindMark  = 2'd2;

  localparam logic CmdChar = 1'b0;

  typedef enum logic [2:0] {
    PH_START,
    PH_FIELD,
    PH_GAP,
    PH_TRAIL,
    PH_REST
  } phase_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SEND
  } back_state_e;

  // Work list for one accepted item, in emission order: held characters,
  // one character, closes, line marker.
  typedef struct packed {
    logic              wr_en;
    logic [HoldAw-1:0] wr_idx;
    logic [7:0]        wr_char;
    logic [5:0]        flush_n;
    logic              ovf;
    logic              ch_en;
    logic [7:0]        ch;
    logic [5:0]        closes;
    logic              mk;
    logic [5:0]        cap;
    logic [7:0]        idx;
  } job_t;

  function automatic logic is_sep(input logic [7:0] c, input logic [63:0] chars,
                                  input logic [3:0] cnt);
    logic [3:0] n;
    logic       r;
    n = (cnt > 4'(IfsSlots)) ? 4'(IfsSlots) : cnt;
    r = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < n) && (chars[8*i +: 8] == c) && (c != 8'd0)) begin
        r = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharNewline);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// ----- src/ifs_front.sv -----
// Front end: configuration registers, line parser and job builder.
module ifs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [7:0]         char_i,
  output logic               push_o,
  output ifs_pkg::job_t      job_o,
  input  logic               full_i
);

  logic [63:0]     ifs_chars_q;
  logic [3:0]      ifs_count_q;
  logic            raw_q;
  logic [6:0]      names_q;

  ifs_pkg::phase_e phase_q, phase_d;
  logic            esc_q, esc_d;
  logic [7:0]      fc_q, fc_d;
  logic            fopen_q, fopen_d;
  logic [5:0]      hcnt_q, hcnt_d;
  logic            hdv_q, hdv_d;
  logic            drop_q, drop_d;

  logic            accept;
  logic            nosplit;
  logic [5:0]      nv;
  logic            do_feed, lit, sep, blank, lastf;
  logic [7:0]      fch;
  logic            f_hb, f_hd, f_flush, f_close, f_emit;
  logic [7:0]      fc1;
  logic [5:0]      k_extra;
  logic [6:0]      total;
  ifs_pkg::job_t   job;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign nosplit    = names_q[6];
  assign nv = (!names_q[6] && (names_q[5:0] > 6'(ifs_pkg::MaxNames))) ?
              6'(ifs_pkg::MaxNames) : names_q[5:0];

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    fc_d    = fc_q;
    fopen_d = fopen_q;
    hcnt_d  = hcnt_q;
    hdv_d   = hdv_q;
    drop_d  = drop_q;
    job     = '0;
    job.idx = fc_q;
    do_feed = 1'b0;
    lit     = 1'b0;
    fch     = char_i;
    f_hb    = 1'b0;
    f_hd    = 1'b0;
    f_flush = 1'b0;
    f_close = 1'b0;
    f_emit  = 1'b0;
    fc1     = 8'd0;
    k_extra = 6'd0;
    if (accept) begin
      if (cmd_i != ifs_pkg::CmdChar) begin
        if (esc_q) begin
          esc_d   = 1'b0;
          do_feed = 1'b1;
          fch     = ifs_pkg::CharBackslash;
        end
      end else if (char_i == 8'd0) begin
        esc_d = esc_q;
      end else if (esc_q) begin
        esc_d   = 1'b0;
        do_feed = 1'b1;
        lit     = 1'b1;
      end else if (!raw_q && (char_i == ifs_pkg::CharBackslash)) begin
        // A backslash that can only be content releases the held blanks now.
        if (!nosplit && ((phase_q == ifs_pkg::PH_REST) ||
            ((phase_q == ifs_pkg::PH_TRAIL) &&
             (!ifs_pkg::is_sep(ifs_pkg::CharBackslash, ifs_chars_q, ifs_count_q) ||
              hdv_q)))) begin
          f_flush = 1'b1;
          phase_d = ifs_pkg::PH_REST;
        end
        esc_d = 1'b1;
      end else begin
        do_feed = 1'b1;
      end
    end

    sep   = !lit && ifs_pkg::is_sep(fch, ifs_chars_q, ifs_count_q);
    blank = sep && ifs_pkg::is_blank(fch);
    lastf = (nv != 6'd0) && (({1'b0, fc_q} + 9'd1) >= {3'b000, nv});

    if (do_feed) begin
      if (nosplit) begin
        f_emit  = 1'b1;
        fopen_d = 1'b1;
      end else begin
        case (phase_q)
          ifs_pkg::PH_FIELD: begin
            if (blank) begin
              if (lastf) begin
                f_hb    = 1'b1;
                phase_d = ifs_pkg::PH_TRAIL;
              end else begin
                f_close = 1'b1;
                phase_d = ifs_pkg::PH_GAP;
              end
            end else if (sep) begin
              if (lastf) begin
                f_hd    = 1'b1;
                phase_d = ifs_pkg::PH_TRAIL;
              end else begin
                f_close = 1'b1;
                phase_d = ifs_pkg::PH_START;
              end
            end else begin
              f_emit = 1'b1;
            end
          end
          ifs_pkg::PH_GAP: begin
            if (blank) begin
              phase_d = ifs_pkg::PH_GAP;
            end else if (sep) begin
              phase_d = ifs_pkg::PH_START;
            end else begin
              fopen_d = 1'b1;
              f_emit  = 1'b1;
              phase_d = ifs_pkg::PH_FIELD;
            end
          end
          ifs_pkg::PH_TRAIL: begin
            if (blank) begin
              f_hb = 1'b1;
            end else if (sep && !hdv_q) begin
              f_hd = 1'b1;
            end else begin
              f_flush = 1'b1;
              f_emit  = 1'b1;
              phase_d = ifs_pkg::PH_REST;
            end
          end
          ifs_pkg::PH_REST: begin
            if (blank) begin
              f_hb = 1'b1;
            end else begin
              f_flush = 1'b1;
              f_emit  = 1'b1;
            end
          end
          default: begin
            phase_d = ifs_pkg::PH_START;
            if (blank) begin
              phase_d = ifs_pkg::PH_START;
            end else if (sep) begin
              if (lastf) begin
                fopen_d = 1'b1;
                f_hd    = 1'b1;
                phase_d = ifs_pkg::PH_TRAIL;
              end else begin
                f_close = 1'b1;
              end
            end else begin
              fopen_d = 1'b1;
              f_emit  = 1'b1;
              phase_d = ifs_pkg::PH_FIELD;
            end
          end
        endcase
      end
    end

    if (f_flush) begin
      job.flush_n = hcnt_q;
      job.ovf     = drop_q;
      hcnt_d      = 6'd0;
      hdv_d       = 1'b0;
      drop_d      = 1'b0;
    end
    if (f_emit) begin
      job.ch_en = 1'b1;
      job.ch    = fch;
    end
    if (f_hb || f_hd) begin
      job.wr_char = fch;
      if (hcnt_q < 6'(ifs_pkg::HoldDepth)) begin
        job.wr_en  = 1'b1;
        job.wr_idx = hcnt_q[ifs_pkg::HoldAw-1:0];
        hcnt_d     = hcnt_q + 6'd1;
      end else begin
        drop_d = 1'b1;
        // A delimiter that finds the hold full replaces its last entry.
        if (f_hd) begin
          job.wr_en  = 1'b1;
          job.wr_idx = ifs_pkg::HoldAw'(ifs_pkg::HoldDepth - 1);
        end
      end
      if (f_hd) begin
        hdv_d = 1'b1;
      end
    end
    if (f_close) begin
      job.closes = 6'd1;
      fc_d       = ifs_pkg::sat_inc(fc_q);
      fopen_d    = 1'b0;
    end

    if (accept && (cmd_i != ifs_pkg::CmdChar)) begin
      hcnt_d = 6'd0;
      hdv_d  = 1'b0;
      drop_d = 1'b0;
      if (nosplit) begin
        job.closes = job.closes + 6'd1;
      end else begin
        fc1     = fopen_d ? ifs_pkg::sat_inc(fc_d) : fc_d;
        k_extra = ({2'b00, nv} > fc1) ? (nv - fc1[5:0]) : 6'd0;
        job.closes = job.closes + {5'd0, fopen_d} + k_extra;
      end
      job.mk  = 1'b1;
      phase_d = ifs_pkg::PH_START;
      fc_d    = 8'd0;
      fopen_d = 1'b0;
    end

    total   = {1'b0, job.flush_n} + {6'd0, job.ch_en} + {1'b0, job.closes} +
              {6'd0, job.mk};
    job.cap = (total > 7'(ifs_pkg::ResultLimit)) ? 6'(ifs_pkg::ResultLimit) : total[5:0];
  end

  assign job_o  = job;
  assign push_o = accept && ((job.cap != 6'd0) || job.wr_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ifs_chars_q <= 64'd657696;
      ifs_count_q <= 4'd3;
      raw_q       <= 1'b0;
      names_q     <= 7'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ifs_pkg::CfgIfsChars:  ifs_chars_q <= cfg_data_i;
        ifs_pkg::CfgIfsCount:  ifs_count_q <= cfg_data_i[3:0];
        ifs_pkg::CfgRawMode:   raw_q       <= cfg_data_i[0];
        ifs_pkg::CfgNameCount: names_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ifs_pkg::PH_START;
      esc_q   <= 1'b0;
      fc_q    <= 8'd0;
      fopen_q <= 1'b0;
      hcnt_q  <= 6'd0;
      hdv_q   <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      fc_q    <= fc_d;
      fopen_q <= fopen_d;
      hcnt_q  <= hcnt_d;
      hdv_q   <= hdv_d;
      drop_q  <= drop_d;
    end
  end

endmodule

// ----- src/ifs_fifo.sv -----
// Short job queue between the parser and the result sequencer.
module ifs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ifs_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ifs_pkg::job_t data_o
);

  ifs_pkg::job_t mem_q [ifs_pkg::FifoDepth];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'(ifs_pkg::FifoDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- src/ifs_back.sv -----
// Back end: blank hold memory and result sequencer with output register.
module ifs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  ifs_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_index_o,
  output logic [1:0]    out_kind_o,
  output logic [7:0]    out_char_o,
  output logic          out_ovf_o,
  output logic          out_last_o
);

  logic [7:0]              hold_mem [ifs_pkg::HoldDepth];
  logic [7:0]              rd_q;
  ifs_pkg::back_state_e    st_q, st_d;
  ifs_pkg::job_t           cur_q;
  logic [5:0]              e_q;
  logic [7:0]              idx_q;
  logic                    valid_q;
  logic [7:0]              index_q, char_q;
  logic [1:0]              kind_q;
  logic                    ovf_q, last_q;

  logic                    out_free, send, is_last, next_flush;
  logic [6:0]              sum_fc, sum_cl;
  logic [1:0]              ev_kind;
  logic [7:0]              ev_char;
  ifs_pkg::back_state_e    start_st;

  assign out_free   = !valid_q || out_ready_i;
  assign sum_fc     = {1'b0, cur_q.flush_n} + {6'd0, cur_q.ch_en};
  assign sum_cl     = sum_fc + {1'b0, cur_q.closes};
  assign is_last    = ((e_q + 6'd1) == cur_q.cap);
  assign next_flush = ((e_q + 6'd1) < cur_q.flush_n);
  assign send       = (st_q == ifs_pkg::B_SEND) && out_free;
  assign pop_o      = job_valid_i &&
                      ((st_q == ifs_pkg::B_IDLE) || (send && is_last));
  assign start_st   = (job_i.cap == 6'd0) ? ifs_pkg::B_IDLE :
                      ((job_i.flush_n != 6'd0) ? ifs_pkg::B_FETCH : ifs_pkg::B_SEND);

  always_comb begin
    if (e_q < cur_q.flush_n) begin
      ev_kind = ifs_pkg::KindChar;
      ev_char = rd_q;
    end else if ({1'b0, e_q} < sum_fc) begin
      ev_kind = ifs_pkg::KindChar;
      ev_char = cur_q.ch;
    end else if ({1'b0, e_q} < sum_cl) begin
      ev_kind = ifs_pkg::KindClose;
      ev_char = 8'd0;
    end else begin
      ev_kind = ifs_pkg::KindMark;
      ev_char = 8'd0;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ifs_pkg::B_IDLE: begin
        if (pop_o) begin
          st_d = start_st;
        end
      end
      ifs_pkg::B_FETCH: st_d = ifs_pkg::B_SEND;
      ifs_pkg::B_SEND: begin
        if (out_free) begin
          if (is_last) begin
            st_d = pop_o ? start_st : ifs_pkg::B_IDLE;
          end else if (next_flush) begin
            st_d = ifs_pkg::B_FETCH;
          end
        end
      end
      default: st_d = ifs_pkg::B_IDLE;
    endcase
  end

  // Held characters are read into a register ahead of their transaction.
  always_ff @(posedge clk_i) begin
    if (pop_o && job_i.wr_en) begin
      hold_mem[job_i.wr_idx] <= job_i.wr_char;
    end
    rd_q <= hold_mem[e_q[ifs_pkg::HoldAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
    if (send) begin
      index_q <= idx_q;
      kind_q  <= ev_kind;
      char_q  <= ev_char;
      ovf_q   <= cur_q.ovf;
      last_q  <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ifs_pkg::B_IDLE;
      e_q     <= 6'd0;
      idx_q   <= 8'd0;
      valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop_o) begin
        e_q   <= 6'd0;
        idx_q <= job_i.idx;
      end else if (send) begin
        e_q <= e_q + 6'd1;
        if (ev_kind == ifs_pkg::KindClose) begin
          idx_q <= ifs_pkg::sat_inc(idx_q);
        end
      end
      if (send) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_index_o = index_q;
  assign out_kind_o  = kind_q;
  assign out_char_o  = char_q;
  assign out_ovf_o   = ovf_q;
  assign out_last_o  = last_q;

endmodule

// ----- src/ifs_field_splitter.sv -----
// Top level of the field splitter: parser, job queue and result sequencer.
// The input stream carries one line: s_axis_tuser 0 with a character in
// s_axis_tdata, then s_axis_tuser 1 to end the line. Each transaction may give
// zero to 34 result transactions on the output stream; tlast marks the final
// result caused by that input transaction. tuser carries the result kind
// (character, field closed, line finished).
// The parser takes one input transaction per cycle while the two-entry job
// queue has room, so an input is accepted while earlier results still wait.
// The sequencer gives one result per cycle while the receiver takes them,
// except for released held separators: each held character takes a hold
// memory read and then its transaction. A line character passes through the
// job queue and the sequencer's job register before the output register.
// Configuration writes are always accepted (cfg_ready_o is high) and should
// only be issued while no line is in flight.
// Reset returns the parser to the start of a line, empties the queue and
// restores the default separator set (space, tab, newline). If the receiver
// stalls, the output register holds, the queue fills and s_axis_tready falls.
module ifs_field_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_char
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] field_index, [15:8] data_char,
                                      // [16] hold_overflow, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  logic          push, full, pop, job_valid;
  ifs_pkg::job_t job_in, job_out;
  logic [7:0]    out_index, out_char;
  logic          out_ovf;

  assign cfg_ready_o = 1'b1;

  ifs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .char_i      (s_axis_tdata),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  ifs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  ifs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_kind_o  (m_axis_tuser),
    .out_char_o  (out_char),
    .out_ovf_o   (out_ovf),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_ovf, out_char, out_index};

endmodule

// ----- src/ifs_checker.sv -----
// Port-level checker of the field splitter and its bind statement.
module ifs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ifs_pkg::KindChar) ||
                      (m_axis_tuser == ifs_pkg::KindClose) ||
                      (m_axis_tuser == ifs_pkg::KindMark))
    else $error("unknown result kind");

  a_mark_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ifs_pkg::KindMark) |-> m_axis_tlast)
    else $error("line marker is not the final result");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ifs_pkg::KindChar) |->
      (m_axis_tdata[15:8] == 8'd0) && (m_axis_tdata[23:17] == 7'd0))
    else $error("non-character result carries data");

endmodule

bind ifs_field_splitter ifs_checker u_ifs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
